// ===== src/arpg_pkg.sv =====
package arpg_pkg;

   localparam int MAX_ORDER = 128;
   localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ORDER_W   = $clog2(MAX_ORDER + 1);

   localparam int SAMPLE_W   = 32;
   localparam int COEF_W     = 24;
   localparam int CINDEX_W   = 7;
   localparam int MORDER_W   = 8;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = 64;
   localparam int FRAC_SHIFT = 20;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic CSR_MODEL_ORDER = 1'b0;
   localparam logic CSR_TRANSIENT   = 1'b1;

   localparam logic [MORDER_W-1:0] MODEL_ORDER_RESET = MORDER_W'(1);
   localparam logic [SAMPLE_W-1:0] TRANSIENT_RESET   = SAMPLE_W'(10000);

   typedef logic [IDX_W-1:0]                  idx_type;
   typedef logic signed [COEF_W-1:0]          coef_type;
   typedef logic signed [SAMPLE_W-1:0]        sample_type;

   typedef struct packed {
      logic       coef_we;
      idx_type    coef_waddr;
      coef_type   coef_wdata;
      logic       rd_en;
      idx_type    coef_raddr;
      idx_type    hist_raddr;
      logic       hist_we;
      idx_type    hist_waddr;
      sample_type hist_wdata;
   } mem_ctrl_type;

   typedef struct packed {
      logic fire;
      logic emit;
   } done_type;

endpackage

// ===== src/arpg_store.sv =====
module arpg_store (
   input  logic                  clock,
   input  logic                  reset,
   input  arpg_pkg::mem_ctrl_type mem_ctrl,
   output logic                  rd_vld,
   output arpg_pkg::coef_type    coef_q,
   output arpg_pkg::sample_type  sample_q
);

   arpg_pkg::coef_type   coef_mem [arpg_pkg::MAX_ORDER];
   arpg_pkg::sample_type hist_mem [arpg_pkg::MAX_ORDER];

   logic [arpg_pkg::MAX_ORDER-1:0] hist_vld_ff;
   logic [arpg_pkg::MAX_ORDER-1:0] hist_vld_in;
   arpg_pkg::coef_type             coef_q_ff;
   arpg_pkg::sample_type           hist_q_ff;
   logic                           vld_q_ff;
   logic                           rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.coef_we) begin
         coef_mem[mem_ctrl.coef_waddr] <= mem_ctrl.coef_wdata;
      end
      if (mem_ctrl.rd_en) begin
         coef_q_ff <= coef_mem[mem_ctrl.coef_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctrl.hist_we) begin
         hist_mem[mem_ctrl.hist_waddr] <= mem_ctrl.hist_wdata;
      end
      if (mem_ctrl.rd_en) begin
         hist_q_ff <= hist_mem[mem_ctrl.hist_raddr];
         vld_q_ff  <= hist_vld_ff[mem_ctrl.hist_raddr];
      end
   end

   // A history entry that was never written since reset reads as zero.
   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (mem_ctrl.hist_we) begin
         hist_vld_in[mem_ctrl.hist_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         hist_vld_ff <= hist_vld_in;
         rd_vld_ff   <= mem_ctrl.rd_en;
      end
   end

   assign rd_vld   = rd_vld_ff;
   assign coef_q   = coef_q_ff;
   assign sample_q = vld_q_ff ? hist_q_ff : '0;

endmodule

// ===== src/arpg_mac.sv =====
module arpg_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 init,
   input  arpg_pkg::sample_type noise,
   input  logic                 rd_vld,
   input  arpg_pkg::coef_type   coef,
   input  arpg_pkg::sample_type sample,
   output logic                 prod_vld,
   output arpg_pkg::sample_type round_value
);

   localparam logic signed [arpg_pkg::ACC_W-1:0] HALF_LSB =
      arpg_pkg::ACC_W'(1) <<< (arpg_pkg::FRAC_SHIFT - 1);
   localparam logic signed [arpg_pkg::ACC_W-1:0] SAT_HI =
      (arpg_pkg::ACC_W'(1) <<< (arpg_pkg::SAMPLE_W - 1)) - arpg_pkg::ACC_W'(1);
   localparam logic signed [arpg_pkg::ACC_W-1:0] SAT_LO =
      -(arpg_pkg::ACC_W'(1) <<< (arpg_pkg::SAMPLE_W - 1));

   logic signed [arpg_pkg::PROD_W-1:0] prod_ff;
   logic signed [arpg_pkg::PROD_W-1:0] prod_in;
   logic                               prod_vld_ff;
   logic signed [arpg_pkg::ACC_W-1:0]  acc_ff;
   logic signed [arpg_pkg::ACC_W-1:0]  acc_in;
   logic signed [arpg_pkg::ACC_W-1:0]  rnd_sum;
   logic signed [arpg_pkg::ACC_W-1:0]  rnd_q;

   assign prod_in = arpg_pkg::PROD_W'(coef) * arpg_pkg::PROD_W'(sample);

   always_comb begin
      acc_in = acc_ff;
      if (init) begin
         acc_in = arpg_pkg::ACC_W'(noise) <<< arpg_pkg::FRAC_SHIFT;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + arpg_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= rd_vld;
      end
   end

   // Round to nearest with ties toward plus infinity, then saturate.
   assign rnd_sum = acc_ff + HALF_LSB;
   assign rnd_q   = rnd_sum >>> arpg_pkg::FRAC_SHIFT;

   always_comb begin
      if (rnd_q > SAT_HI) begin
         round_value = SAT_HI[arpg_pkg::SAMPLE_W-1:0];
      end else if (rnd_q < SAT_LO) begin
         round_value = SAT_LO[arpg_pkg::SAMPLE_W-1:0];
      end else begin
         round_value = rnd_q[arpg_pkg::SAMPLE_W-1:0];
      end
   end

   assign prod_vld = prod_vld_ff;

endmodule

// ===== src/arpg_seq.sv =====
module arpg_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [arpg_pkg::CINDEX_W-1:0]     req_coef_index,
   input  arpg_pkg::coef_type                req_coef_value,
   input  logic [arpg_pkg::MORDER_W-1:0]     model_order,
   input  logic [arpg_pkg::SAMPLE_W-1:0]     transient_steps,
   input  logic                              rd_vld,
   input  logic                              prod_vld,
   input  logic                              rsp_free,
   input  arpg_pkg::sample_type              round_value,
   output arpg_pkg::mem_ctrl_type            mem_ctrl,
   output logic                              mac_init,
   output arpg_pkg::done_type                done
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } seq_state_type;

   seq_state_type                   state_ff, state_in;
   arpg_pkg::idx_type               ring_pos_ff, ring_pos_in;
   arpg_pkg::idx_type               pos_ff, pos_in;
   arpg_pkg::idx_type               last_ff, last_in;
   arpg_pkg::idx_type               tap_cnt_ff, tap_cnt_in;
   arpg_pkg::idx_type               hist_idx_ff, hist_idx_in;
   logic [arpg_pkg::SAMPLE_W-1:0]   steps_ff, steps_in;

   logic [arpg_pkg::ORDER_W-1:0]    eff_order;
   arpg_pkg::idx_type               eff_last;
   arpg_pkg::idx_type               start_pos;
   logic                            accept;
   logic                            fire;
   logic                            emit;

   always_comb begin
      if (model_order == '0) begin
         eff_order = arpg_pkg::ORDER_W'(1);
      end else if (32'(model_order) > 32'(arpg_pkg::MAX_ORDER)) begin
         eff_order = arpg_pkg::ORDER_W'(arpg_pkg::MAX_ORDER);
      end else begin
         eff_order = arpg_pkg::ORDER_W'(model_order);
      end
   end

   assign eff_last  = arpg_pkg::IDX_W'(eff_order - arpg_pkg::ORDER_W'(1));
   assign start_pos = (arpg_pkg::ORDER_W'(ring_pos_ff) < eff_order) ? ring_pos_ff : '0;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign fire   = (state_ff == ST_FINISH) && rsp_free;
   assign emit   = steps_ff >= transient_steps;

   always_comb begin
      state_in    = state_ff;
      ring_pos_in = ring_pos_ff;
      pos_in      = pos_ff;
      last_in     = last_ff;
      tap_cnt_in  = tap_cnt_ff;
      hist_idx_in = hist_idx_ff;
      steps_in    = steps_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == arpg_pkg::CMD_STEP)) begin
               state_in    = ST_ISSUE;
               pos_in      = start_pos;
               last_in     = eff_last;
               tap_cnt_in  = '0;
               hist_idx_in = (start_pos == '0) ? eff_last
                                               : start_pos - arpg_pkg::IDX_W'(1);
            end
         end
         ST_ISSUE: begin
            if (tap_cnt_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               tap_cnt_in  = tap_cnt_ff + arpg_pkg::IDX_W'(1);
               hist_idx_in = (hist_idx_ff == '0) ? last_ff
                                                 : hist_idx_ff - arpg_pkg::IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!rd_vld && !prod_vld) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in    = ST_IDLE;
               ring_pos_in = (pos_ff == last_ff) ? '0 : pos_ff + arpg_pkg::IDX_W'(1);
               if (steps_ff != '1) begin
                  steps_in = steps_ff + arpg_pkg::SAMPLE_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ring_pos_ff <= '0;
         steps_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         ring_pos_ff <= ring_pos_in;
         steps_ff    <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      tap_cnt_ff  <= tap_cnt_in;
      hist_idx_ff <= hist_idx_in;
   end

   always_comb begin
      mem_ctrl.coef_we    = accept && (req_cmd == arpg_pkg::CMD_LOAD) &&
                            (32'(req_coef_index) < 32'(arpg_pkg::MAX_ORDER));
      mem_ctrl.coef_waddr = arpg_pkg::IDX_W'(req_coef_index);
      mem_ctrl.coef_wdata = req_coef_value;
      mem_ctrl.rd_en      = (state_ff == ST_ISSUE);
      mem_ctrl.coef_raddr = tap_cnt_ff;
      mem_ctrl.hist_raddr = hist_idx_ff;
      mem_ctrl.hist_we    = fire;
      mem_ctrl.hist_waddr = pos_ff;
      mem_ctrl.hist_wdata = round_value;
   end

   assign mac_init  = accept && (req_cmd == arpg_pkg::CMD_STEP);
   assign req_stall = (state_ff != ST_IDLE);
   assign done.fire = fire;
   assign done.emit = emit;

endmodule

// ===== src/autoregressive_process_generator_top.sv =====
// Channel   Direction  Handshake          Contents
// req_*     in         req_valid/stall    cmd, coef_index, coef_value, noise
// rsp_*     out        rsp_valid/stall    value
// csr_*     in         csr_we             csr_index, csr_wdata
//
// A load transaction is written to the coefficient table in the cycle it is taken;
// a step is run by the single multiply-accumulate unit that walks one tap per cycle.
// Reset is synchronous; the history ring reads as zero until each entry is written.
// A step finishes only once the output register is free, so a stalled result holds
// the block in its last cycle; loads are still taken while a result waits.
module autoregressive_process_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [arpg_pkg::CINDEX_W-1:0]       req_coef_index,
   input  logic signed [arpg_pkg::COEF_W-1:0]  req_coef_value,
   input  logic signed [arpg_pkg::SAMPLE_W-1:0] req_noise,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [arpg_pkg::SAMPLE_W-1:0] rsp_value,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [arpg_pkg::SAMPLE_W-1:0]       csr_wdata
);

   logic [arpg_pkg::MORDER_W-1:0] model_order_ff;
   logic [arpg_pkg::SAMPLE_W-1:0] transient_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   arpg_pkg::sample_type          rsp_value_ff;

   arpg_pkg::mem_ctrl_type        mem_ctrl;
   arpg_pkg::done_type            done;
   logic                          rd_vld;
   logic                          prod_vld;
   logic                          mac_init;
   logic                          rsp_free;
   arpg_pkg::coef_type            coef_q;
   arpg_pkg::sample_type          sample_q;
   arpg_pkg::sample_type          round_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_order_ff <= arpg_pkg::MODEL_ORDER_RESET;
         transient_ff   <= arpg_pkg::TRANSIENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            arpg_pkg::CSR_MODEL_ORDER: begin
               model_order_ff <= csr_wdata[arpg_pkg::MORDER_W-1:0];
            end
            arpg_pkg::CSR_TRANSIENT: begin
               transient_ff <= csr_wdata;
            end
            default: begin
               model_order_ff <= model_order_ff;
            end
         endcase
      end
   end

   arpg_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .model_order     (model_order_ff),
      .transient_steps (transient_ff),
      .rd_vld          (rd_vld),
      .prod_vld        (prod_vld),
      .rsp_free        (rsp_free),
      .round_value     (round_value),
      .mem_ctrl        (mem_ctrl),
      .mac_init        (mac_init),
      .done            (done)
   );

   arpg_store u_store (
      .clock    (clock),
      .reset    (reset),
      .mem_ctrl (mem_ctrl),
      .rd_vld   (rd_vld),
      .coef_q   (coef_q),
      .sample_q (sample_q)
   );

   arpg_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .init        (mac_init),
      .noise       (req_noise),
      .rd_vld      (rd_vld),
      .coef        (coef_q),
      .sample      (sample_q),
      .prod_vld    (prod_vld),
      .round_value (round_value)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (done.fire && done.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done.fire && done.emit) begin
         rsp_value_ff <= round_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // A step transaction keeps the block busy until its result is finished.
   a_step_goes_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == arpg_pkg::CMD_STEP) |=> req_stall)
      else $error("step transaction did not make the block busy");

   // A load transaction completes in the cycle it is taken.
   a_load_stays_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == arpg_pkg::CMD_LOAD) |=> !req_stall)
      else $error("load transaction made the block busy");

   // A step never finishes over a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done.fire |-> !(rsp_valid_ff && rsp_stall))
      else $error("step finished while the output register was held");

   // A new result appears only at the end of a step that emits.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(done.fire && done.emit))
      else $error("result appeared without a finishing step");

endmodule

// ===== dv/tb_autoregressive_process_generator_top.sv =====
`timescale 1ns / 1ps

module tb_autoregressive_process_generator_top;

   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int DIR_COUNT     = 29;
   localparam int PHASE_COUNT   = 8;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic                              csr_sel;
      logic [31:0]                       csr_data;
      logic                              cmd;
      logic [arpg_pkg::CINDEX_W-1:0]     idx;
      arpg_pkg::coef_type                coef;
      arpg_pkg::sample_type              noise;
      logic                              typed;
      arpg_pkg::sample_type              want;
   } dir_row_type;

   typedef struct packed {
      logic [31:0] order_word;
      logic        relative;
      logic [31:0] transient;
      logic [15:0] count;
      logic [1:0]  mode;
   } phase_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_cmd;
   logic [arpg_pkg::CINDEX_W-1:0]         req_coef_index;
   logic signed [arpg_pkg::COEF_W-1:0]    req_coef_value;
   logic signed [arpg_pkg::SAMPLE_W-1:0]  req_noise;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [arpg_pkg::SAMPLE_W-1:0]  rsp_value;
   logic                                  csr_we;
   logic                                  csr_index;
   logic [arpg_pkg::SAMPLE_W-1:0]         csr_wdata;

   arpg_pkg::coef_type    coef_tab [arpg_pkg::MAX_ORDER];
   arpg_pkg::sample_type  hist_ring [arpg_pkg::MAX_ORDER];
   bit                    coef_loaded [arpg_pkg::MAX_ORDER];
   int                    ring_pos;
   logic [31:0]           steps_done;
   logic [7:0]            cfg_order;
   logic [31:0]           cfg_transient;
   arpg_pkg::sample_type  expected_samples [$];
   arpg_pkg::sample_type  oldest_sample;
   int                    errors = 0;
   int                    send_pct;
   int                    recv_pct;
   longint                cycles = 0;

   dir_row_type dir_rows [DIR_COUNT] = '{
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'sh000000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh7FFFFFFF, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh80000000, 1'b0, 32'sh0},
      '{ROW_CSR,  arpg_pkg::CSR_TRANSIENT,   32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'sh000000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh1, 1'b1, 32'sh1},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'sh7FFFFF,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'sh800000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh0, 1'b1, 32'sh80000000},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh80000000, 1'b1, 32'sh7FFFFFFF},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'sh100000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh80000000, 1'b1, 32'shFFFFFFFF},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'sh000000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh1, 1'b1, 32'sh1},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'sh080000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh0, 1'b1, 32'sh1},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd0, 24'shF80000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh0, 1'b1, 32'sh0},
      '{ROW_CSR,  arpg_pkg::CSR_MODEL_ORDER, 32'hFFFFFF00, arpg_pkg::CMD_LOAD, 7'd0,
        24'sh000000, 32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh00010000, 1'b1, 32'sh00010000},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd1, 24'sh040000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd2, 24'shFC0000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_LOAD, 7'd127, 24'sh555555,
        32'shAAAAAAAA, 1'b0, 32'sh0},
      '{ROW_CSR,  arpg_pkg::CSR_MODEL_ORDER, 32'd3, arpg_pkg::CMD_LOAD, 7'd0, 24'sh000000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh00020000, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'shFFFE0000, 1'b0, 32'sh0},
      '{ROW_CSR,  arpg_pkg::CSR_MODEL_ORDER, 32'd2, arpg_pkg::CMD_LOAD, 7'd0, 24'sh000000,
        32'sh0, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh12345678, 1'b0, 32'sh0},
      '{ROW_ITEM, arpg_pkg::CSR_MODEL_ORDER, 32'd0, arpg_pkg::CMD_STEP, 7'd0, 24'sh000000,
        32'sh0, 1'b0, 32'sh0}
   };

   phase_type phases [PHASE_COUNT] = '{
      '{32'h00000004, 1'b1, 32'd6,          16'd300, 2'd0},
      '{32'h00000080, 1'b0, 32'd0,          16'd250, 2'd0},
      '{32'hABCD0005, 1'b0, 32'd0,          16'd250, 2'd1},
      '{32'h000000FF, 1'b0, 32'hFFFFFFFF,   16'd60,  2'd1},
      '{32'h00000001, 1'b0, 32'd0,          16'd250, 2'd1},
      '{32'h00000010, 1'b1, 32'd20,         16'd300, 2'd2},
      '{32'h00000002, 1'b0, 32'd0,          16'd300, 2'd2},
      '{32'h00000100, 1'b0, 32'd3,          16'd150, 2'd2}
   };

   autoregressive_process_generator_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_noise      (req_noise),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int order_in_use();
      if (cfg_order == 8'd0) return 1;
      if (int'(cfg_order) > arpg_pkg::MAX_ORDER) return arpg_pkg::MAX_ORDER;
      return int'(cfg_order);
   endfunction

   // Applies one accepted transaction to the process state and queues the sample it emits.
   task automatic apply_transaction(logic cmd, logic [arpg_pkg::CINDEX_W-1:0] idx,
                                    arpg_pkg::coef_type coef, arpg_pkg::sample_type noise,
                                    logic typed, arpg_pkg::sample_type want);
      int                   order;
      int                   pos;
      int                   j;
      longint               acc;
      arpg_pkg::sample_type sample;
      if (cmd == arpg_pkg::CMD_LOAD) begin
         coef_tab[idx] = coef;
         coef_loaded[idx] = 1'b1;
         return;
      end
      order = order_in_use();
      pos = (ring_pos >= order) ? 0 : ring_pos;
      acc = longint'(noise) <<< arpg_pkg::FRAC_SHIFT;
      for (j = 0; j < order; j++) begin
         acc = acc + longint'(coef_tab[j]) * longint'(hist_ring[(pos + order - j - 1) % order]);
      end
      acc = (acc + (longint'(1) <<< (arpg_pkg::FRAC_SHIFT - 1))) >>> arpg_pkg::FRAC_SHIFT;
      if (acc > 64'sd2147483647) begin
         sample = 32'sh7FFFFFFF;
      end else if (acc < -64'sd2147483648) begin
         sample = 32'sh80000000;
      end else begin
         sample = arpg_pkg::sample_type'(acc);
      end
      hist_ring[pos] = sample;
      pos++;
      if (pos >= order) pos = 0;
      ring_pos = pos;
      if (steps_done >= cfg_transient) expected_samples.push_back(typed ? want : sample);
      if (steps_done != 32'hFFFFFFFF) steps_done++;
   endtask

   task automatic send(logic cmd, logic [arpg_pkg::CINDEX_W-1:0] idx,
                       arpg_pkg::coef_type coef, arpg_pkg::sample_type noise,
                       logic typed, arpg_pkg::sample_type want);
      while (int'($urandom_range(0, 99)) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_coef_index <= idx;
      req_coef_value <= coef;
      req_noise      <= noise;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_transaction(cmd, idx, coef, noise, typed, want);
      @(negedge clock);
   endtask

   task automatic drain(int extra);
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_samples.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_csr(logic sel, logic [31:0] data);
      drain(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == arpg_pkg::CSR_MODEL_ORDER) begin
         cfg_order = data[7:0];
      end else begin
         cfg_transient = data;
      end
   endtask

   function automatic arpg_pkg::coef_type pick_coef();
      int r;
      int bound;
      r = $urandom_range(0, 99);
      bound = (1 << arpg_pkg::FRAC_SHIFT) / order_in_use();
      if (r < 50) return arpg_pkg::coef_type'(int'($urandom_range(0, 2 * bound)) - bound);
      if (r < 65) return arpg_pkg::coef_type'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      if (r < 90) return arpg_pkg::coef_type'($urandom);
      case ($urandom_range(0, 2))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         default: return 24'sh000000;
      endcase
   endfunction

   function automatic arpg_pkg::sample_type pick_noise();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return arpg_pkg::sample_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      if (r < 80) return arpg_pkg::sample_type'($urandom);
      case ($urandom_range(0, 3))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'shFFFFFFFF;
         default: return 32'sh0;
      endcase
   endfunction

   // A step is turned into a load while any coefficient it would read is still unwritten.
   task automatic random_item();
      logic                          cmd;
      logic [arpg_pkg::CINDEX_W-1:0] idx;
      int                            j;
      int                            slot;
      cmd = (int'($urandom_range(0, 99)) < 65) ? arpg_pkg::CMD_STEP : arpg_pkg::CMD_LOAD;
      idx = arpg_pkg::CINDEX_W'($urandom_range(0, arpg_pkg::MAX_ORDER - 1));
      if (cmd == arpg_pkg::CMD_STEP) begin
         slot = -1;
         for (j = order_in_use() - 1; j >= 0; j--) begin
            if (!coef_loaded[j]) slot = j;
         end
         if (slot >= 0) begin
            cmd = arpg_pkg::CMD_LOAD;
            idx = arpg_pkg::CINDEX_W'(slot);
         end
      end
      send(cmd, idx, pick_coef(), pick_noise(), 1'b0, '0);
   endtask

   always @(negedge clock) begin
      rsp_stall <= (int'($urandom_range(0, 99)) < recv_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual value %h",
                     $time, rsp_value);
         end else begin
            oldest_sample = expected_samples.pop_front();
            if (rsp_value !== oldest_sample) begin
               errors++;
               $display("%0t: value mismatch, expected %h, actual %h",
                        $time, oldest_sample, rsp_value);
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = arpg_pkg::CMD_LOAD;
      req_coef_index = '0;
      req_coef_value = '0;
      req_noise      = '0;
      csr_we         = 1'b0;
      csr_index      = arpg_pkg::CSR_MODEL_ORDER;
      csr_wdata      = '0;
      for (int i = 0; i < arpg_pkg::MAX_ORDER; i++) begin
         coef_tab[i]    = '0;
         hist_ring[i]   = '0;
         coef_loaded[i] = 1'b0;
      end
      ring_pos      = 0;
      steps_done    = '0;
      cfg_order     = arpg_pkg::MODEL_ORDER_RESET;
      cfg_transient = arpg_pkg::TRANSIENT_RESET;
      send_pct      = 27;
      recv_pct      = 46;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_COUNT; r++) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            write_csr(dir_rows[r].csr_sel, dir_rows[r].csr_data);
         end else begin
            send(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].coef, dir_rows[r].noise,
                 dir_rows[r].typed, dir_rows[r].want);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (phases[p].mode)
            2'd0: begin
               send_pct = 27;
               recv_pct = 46;
            end
            2'd1: begin
               send_pct = 46;
               recv_pct = 27;
            end
            default: begin
               send_pct = 0;
               recv_pct = 0;
            end
         endcase
         write_csr(arpg_pkg::CSR_MODEL_ORDER, phases[p].order_word);
         write_csr(arpg_pkg::CSR_TRANSIENT, phases[p].relative
                                            ? steps_done + phases[p].transient
                                            : phases[p].transient);
         for (int n = 0; n < int'(phases[p].count); n++) begin
            if ($urandom_range(0, 99) == 0) drain(0);
            random_item();
         end
      end

      drain(SETTLE_CYCLES);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
